// ===== design/sfof_pkg.sv =====
// Shared types, character codes and base translation for the six-frame ORF finder.
package sfof_pkg;

	localparam int CODON = 3;
	localparam logic [2:0] LAST_FRAME = 3'd5;

	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_C  = 8'h43;
	localparam logic [7:0] CH_G  = 8'h47;
	localparam logic [7:0] CH_N  = 8'h4E;
	localparam logic [7:0] CH_R  = 8'h52;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_U  = 8'h55;
	localparam logic [7:0] CH_Y  = 8'h59;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_PULL   = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} sfof_mode_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       append;
		logic       clear;
		logic       frame0;
		logic       frame_next;
		logic       rd_en;
		logic [1:0] rd_off;
		logic       cap0;
		logic       cap1;
		logic       step;
		logic       stop_take;
		logic       res_orf;
		logic       res_trail;
		logic       res_done;
		logic       emit;
	} sfof_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic codon_fits;
		logic stop_hit;
		logic orf_open;
		logic trail_ok;
		logic last_frame;
		logic out_free;
	} sfof_sts_t;

	// Fold case, then map onto the strand being scanned.
	function automatic logic [7:0] base_xlate(input logic [7:0] c, input logic rev);
		logic [7:0] u;
		logic [7:0] r;
		u = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFFSET : c;
		if (!rev) begin
			r = (u == CH_U) ? CH_T : u;
		end else begin
			case (u)
				CH_A:    r = CH_T;
				CH_C:    r = CH_G;
				CH_G:    r = CH_C;
				CH_T:    r = CH_A;
				CH_U:    r = CH_A;
				CH_R:    r = CH_Y;
				CH_Y:    r = CH_R;
				default: r = CH_N;
			endcase
		end
		return r;
	endfunction

	// (a - b) mod 3 for a, b in 0..2.
	function automatic logic [1:0] mod3_sub(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] d;
		d = {1'b0, a} + 3'd3 - {1'b0, b};
		return (d >= 3'd3) ? 2'(d - 3'd3) : d[1:0];
	endfunction

endpackage

// ===== design/sfof_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/sfof_dp.sv =====
// Datapath: sequence store, scan pointers, codon test and result registers.
module sfof_dp
	import sfof_pkg::*;
#(
	parameter int MAX_BASES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sfof_cmd_t   cmd,
	output sfof_sts_t   sts,
	input  logic [7:0]  base_char,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tuser
);

	localparam int AW = $clog2(MAX_BASES);
	localparam int LW = $clog2(MAX_BASES + 1);

	logic [LW-1:0] len_q;
	logic [1:0]    lenmod3_q;
	logic          ovf_q;
	logic [2:0]    frame_q;
	logic [LW-1:0] pos_q;
	logic [LW-1:0] start_q;
	logic [7:0]    b0_q;
	logic [7:0]    b1_q;

	logic [2:0]  res_frame_q;
	logic [15:0] res_start_q;
	logic [15:0] res_end_q;
	logic        res_done_q;
	logic        res_ovf_q;

	logic        out_valid_q;
	logic [2:0]  out_frame_q;
	logic [15:0] out_start_q;
	logic [15:0] out_end_q;
	logic        out_done_q;
	logic        out_ovf_q;

	logic          rev;
	logic [1:0]    off;
	logic [2:0]    frame_val;
	logic [2:0]    frame_inc;
	logic [LW-1:0] rd_idx;
	logic [LW-1:0] rd_pos;
	logic [7:0]    rd_data;
	logic [7:0]    base_t;
	logic [LW:0]   fit_diff;
	logic [LW:0]   trail_diff;
	logic [LW-1:0] trail_end;
	logic          room;

	assign rev       = frame_q[0];
	assign off       = frame_q[2:1];
	assign frame_val = rev ? 3'(-({1'b0, off} + 3'd1)) : {1'b0, off} + 3'd1;
	assign frame_inc = frame_q + 3'd1;
	assign room      = len_q < LW'(MAX_BASES);

	// Strand index to store address; reverse strand counts from the far end.
	assign rd_idx = pos_q + LW'(cmd.rd_off);
	assign rd_pos = rev ? len_q - LW'(1) - rd_idx : rd_idx;

	sfof_ram #(
		.WIDTH (8),
		.DEPTH (MAX_BASES)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.append && room),
		.wr_addr (len_q[AW-1:0]),
		.wr_data (base_char),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_pos[AW-1:0]),
		.rd_data (rd_data)
	);

	assign base_t     = base_xlate(rd_data, rev);
	assign fit_diff   = {1'b0, len_q} - {1'b0, pos_q};
	assign trail_diff = {1'b0, len_q} - {1'b0, start_q};
	assign trail_end  = len_q - LW'(1) - LW'(mod3_sub(lenmod3_q, off));

	always_comb begin
		sts.codon_fits = !fit_diff[LW] && (fit_diff >= (LW+1)'(CODON));
		sts.stop_hit   = (b0_q == CH_T) &&
			(((b1_q == CH_A) && ((base_t == CH_A) || (base_t == CH_G))) ||
			 ((b1_q == CH_G) && (base_t == CH_A)));
		sts.orf_open   = pos_q > start_q;
		sts.trail_ok   = !trail_diff[LW] && (trail_diff >= (LW+1)'(CODON));
		sts.last_frame = frame_q == LAST_FRAME;
		sts.out_free   = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			lenmod3_q <= '0;
			ovf_q     <= 1'b0;
			frame_q   <= '0;
			pos_q     <= '0;
			start_q   <= '0;
		end else begin
			if (cmd.append) begin
				if (room) begin
					len_q     <= len_q + LW'(1);
					lenmod3_q <= (lenmod3_q == 2'd2) ? 2'd0 : lenmod3_q + 2'd1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.clear) begin
				len_q     <= '0;
				lenmod3_q <= '0;
				ovf_q     <= 1'b0;
			end
			if (cmd.frame0) begin
				frame_q <= '0;
				pos_q   <= '0;
				start_q <= '0;
			end
			if (cmd.frame_next) begin
				frame_q <= frame_inc;
				pos_q   <= LW'(frame_inc[2:1]);
				start_q <= LW'(frame_inc[2:1]);
			end
			if (cmd.step) begin
				pos_q <= pos_q + LW'(CODON);
			end
			if (cmd.stop_take) begin
				start_q <= pos_q + LW'(CODON);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap0) begin
			b0_q <= base_t;
		end
		if (cmd.cap1) begin
			b1_q <= base_t;
		end
		if (cmd.res_orf) begin
			res_frame_q <= frame_val;
			res_start_q <= 16'(start_q);
			res_end_q   <= 16'(pos_q - LW'(1));
			res_done_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
		end
		if (cmd.res_trail) begin
			res_frame_q <= frame_val;
			res_start_q <= 16'(start_q);
			res_end_q   <= 16'(trail_end);
			res_done_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
		end
		if (cmd.res_done) begin
			res_frame_q <= '0;
			res_start_q <= '0;
			res_end_q   <= '0;
			res_done_q  <= 1'b1;
			res_ovf_q   <= ovf_q;
		end
		if (cmd.emit) begin
			out_frame_q <= res_frame_q;
			out_start_q <= res_start_q;
			out_end_q   <= res_end_q;
			out_done_q  <= res_done_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_ovf_q, out_end_q, out_start_q, out_frame_q};
	assign m_tuser  = out_done_q;

endmodule

// ===== design/sfof_ctrl.sv =====
// Controller: input handshake, search phase and codon scan sequencing.
module sfof_ctrl
	import sfof_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] mode,
	input  sfof_sts_t  sts,
	output sfof_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_RD1   = 7'b0000100,
		ST_RD2   = 7'b0001000,
		ST_EVAL  = 7'b0010000,
		ST_TRAIL = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} sfof_state_t;

	typedef enum logic [2:0] {
		PH_LOADING = 3'b001,
		PH_SCAN    = 3'b010,
		PH_DONE    = 3'b100
	} sfof_phase_t;

	sfof_state_t state_q, state_d;
	sfof_phase_t phase_q, phase_d;
	logic        take;

	assign s_tready = state_q == ST_IDLE;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (sfof_mode_t'(mode))
						MODE_APPEND: begin
							cmd.append = 1'b1;
							phase_d    = PH_LOADING;
						end
						MODE_CLEAR: begin
							cmd.clear = 1'b1;
							phase_d   = PH_LOADING;
						end
						MODE_PULL: begin
							if (phase_q == PH_DONE) begin
								cmd.res_done = 1'b1;
								state_d      = ST_EMIT;
							end else begin
								if (phase_q == PH_LOADING) begin
									cmd.frame0 = 1'b1;
									phase_d    = PH_SCAN;
								end
								state_d = ST_CHECK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (sts.codon_fits) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_RD1;
				end else begin
					state_d = ST_TRAIL;
				end
			end
			ST_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_off = 2'd1;
				cmd.cap0   = 1'b1;
				state_d    = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_off = 2'd2;
				cmd.cap1   = 1'b1;
				state_d    = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.step = 1'b1;
				state_d  = ST_CHECK;
				if (sts.stop_hit) begin
					cmd.stop_take = 1'b1;
					if (sts.orf_open) begin
						cmd.res_orf = 1'b1;
						state_d     = ST_EMIT;
					end
				end
			end
			ST_TRAIL: begin
				if (sts.last_frame) begin
					phase_d = PH_DONE;
				end else begin
					cmd.frame_next = 1'b1;
				end
				if (sts.trail_ok) begin
					cmd.res_trail = 1'b1;
					state_d       = ST_EMIT;
				end else if (sts.last_frame) begin
					cmd.res_done = 1'b1;
					state_d      = ST_EMIT;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LOADING;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

// ===== design/six_frame_orf_finder.sv =====
// Top level of the six-frame open reading frame finder.
// Append, clear and ignored beats give no result. A pull is accepted, then runs per codon
// three store reads and a compare, per frame end a fit check and a tail, then an emit
// step that waits for a free output register; the beat shows the cycle after the emit.
// Beats are taken one at a time; one waiting result does not block the next beat.
// Reset (arst_n low): empty sequence, overflow flag clear, search back at frame +1.
module six_frame_orf_finder
	import sfof_pkg::*;
#(
	parameter int MAX_BASES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] base_char
	input  logic [1:0]  s_tuser,   // [1:0] mode
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [2:0] reading_frame, [18:3] orf_start,
	                               // [34:19] orf_end, [35] overflowed, rest zero
	output logic        m_tuser    // [0] done_res
);

	sfof_cmd_t cmd;
	sfof_sts_t sts;

	// Controller sequences the scan: check fit, three reads, evaluate, frame end.
	sfof_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath holds the store, pointers and the output register.
	sfof_dp #(
		.MAX_BASES (MAX_BASES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.base_char (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// A done beat carries no frame or coordinates.
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[34:0] == 35'd0)
		else $error("done beat carries ORF fields");

	// An ORF beat has a nonzero frame and no overflow mark.
	a_orf_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[2:0] != 3'd0 && !m_tdata[35])
		else $error("ORF beat with bad frame or overflow mark");

	// A pull holds off further input while it is worked on.
	a_pull_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == MODE_PULL |=> !s_tready)
		else $error("input taken during a pull");

	// Appends, clears and ignored beats never start a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != MODE_PULL |=> !$rose(m_tvalid))
		else $error("result without a pull");

endmodule
